// ===== rtl/core/rgba_blend_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_blend_pkg
// Shared types, codes and helpers of the RGBA8888 blend pipeline.
// ----------------------------------------------------------------------------
package rgba_blend_pkg;

   localparam int CHAN_WIDTH  = 8;
   localparam int PROD_WIDTH  = 2 * CHAN_WIDTH;
   localparam int COLORS      = 3;
   localparam int DIV_STAGES  = PROD_WIDTH;
   localparam int CSR_IDX_W   = 2;
   localparam logic [CHAN_WIDTH-1:0] CHAN_MAX = '1;
   localparam logic [CHAN_WIDTH-1:0] CHAN_HALF = 8'd128;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLEND_MODE  = 2'd0,
      CSR_SRC_OPACITY = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_NORMAL   = 3'd0,
      MODE_ADD      = 3'd1,
      MODE_SUB      = 3'd2,
      MODE_MULTIPLY = 3'd3,
      MODE_DODGE    = 3'd4,
      MODE_BURN     = 3'd5,
      MODE_SCREEN   = 3'd6,
      MODE_OVERLAY  = 3'd7
   } mode_type;

   typedef logic [COLORS-1:0][CHAN_WIDTH-1:0] color_type;
   typedef logic [COLORS-1:0][PROD_WIDTH-1:0] prod_type;

   typedef struct packed {
      mode_type               mode;
      logic                   sa_zero;
      logic                   k_zero;
      logic [CHAN_WIDTH-1:0]  da;
      logic [CHAN_WIDTH-1:0]  sa;
      logic [CHAN_WIDTH-1:0]  t;
      color_type              d;
      color_type              s;
   } side_type;

   // exact floor(x / 255) for products of two 8-bit values
   function automatic logic [CHAN_WIDTH-1:0] div255(input logic [PROD_WIDTH-1:0] x);
      logic [PROD_WIDTH:0] acc;
      acc = {1'b0, x} + {{PROD_WIDTH{1'b0}}, 1'b1}
            + {{(CHAN_WIDTH+1){1'b0}}, x[PROD_WIDTH-1:CHAN_WIDTH]};
      return acc[PROD_WIDTH-1:CHAN_WIDTH];
   endfunction

endpackage

// ===== rtl/core/rgba_blend_eight_modes_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_blend_eight_modes_top
// Blends one source RGBA8888 pixel onto one destination pixel in one of
// eight modes, with a global source opacity.
// ----------------------------------------------------------------------------
// A pixel is taken in every clock cycle; busy never rises. Each result
// appears on the rsp_ ports, registered after the divider, for one
// cycle, with rsp_valid high, and must be captured then. Six front stages
// scale alpha and form products; a 16-stage restoring divider, one quotient
// bit a stage and one per color channel, sets most of the latency. Write
// blend_mode and src_opacity only while no pixel is in flight.
module rgba_blend_eight_modes_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [rgba_blend_pkg::CHAN_WIDTH-1:0] req_dst_red,
   input  logic [rgba_blend_pkg::CHAN_WIDTH-1:0] req_dst_green,
   input  logic [rgba_blend_pkg::CHAN_WIDTH-1:0] req_dst_blue,
   input  logic [rgba_blend_pkg::CHAN_WIDTH-1:0] req_dst_alpha,
   input  logic [rgba_blend_pkg::CHAN_WIDTH-1:0] req_src_red,
   input  logic [rgba_blend_pkg::CHAN_WIDTH-1:0] req_src_green,
   input  logic [rgba_blend_pkg::CHAN_WIDTH-1:0] req_src_blue,
   input  logic [rgba_blend_pkg::CHAN_WIDTH-1:0] req_src_alpha,
   output logic                                rsp_valid,
   output logic [rgba_blend_pkg::CHAN_WIDTH-1:0] rsp_out_red,
   output logic [rgba_blend_pkg::CHAN_WIDTH-1:0] rsp_out_green,
   output logic [rgba_blend_pkg::CHAN_WIDTH-1:0] rsp_out_blue,
   output logic [rgba_blend_pkg::CHAN_WIDTH-1:0] rsp_out_alpha,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rgba_blend_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rgba_blend_pkg::CHAN_WIDTH-1:0] csr_data
);
   import rgba_blend_pkg::*;

   localparam int SW = PROD_WIDTH + 2;

   mode_type              blend_mode_ff;
   logic [CHAN_WIDTH-1:0] src_opacity_ff;

   logic                  v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   color_type             dc1_ff, sc1_ff, dc2_ff, sc2_ff, dc3_ff, sc3_ff;
   logic [CHAN_WIDTH-1:0] da1_ff, da2_ff, da3_ff, sa2_ff, sa3_ff;
   logic [PROD_WIDTH-1:0] p1_ff, kp3_ff;
   side_type              side4_ff, side5_ff, side6_ff;
   side_type              side4_in;
   prod_type              pa5_ff, pb5_ff, pc5_ff, pd5_ff, pf5_ff;
   prod_type              num6_ff, num6_in;
   color_type             den6_ff, den6_in;

   logic     [DIV_STAGES-1:0] vdiv_ff;
   side_type                  sdiv_ff  [DIV_STAGES];
   prod_type                  nq_ff    [DIV_STAGES];
   prod_type                  nq_in    [DIV_STAGES];
   color_type                 rem_ff   [DIV_STAGES];
   color_type                 rem_in   [DIV_STAGES];
   color_type                 den_ff   [DIV_STAGES];
   color_type                 den_src  [DIV_STAGES];

   logic                  out_valid_ff;
   color_type             out_color_ff, out_color_in;
   logic [CHAN_WIDTH-1:0] out_alpha_ff, out_alpha_in;

   logic [CHAN_WIDTH-1:0] k4;
   logic [CHAN_WIDTH:0]   t4;

   // recover k from the carried total alpha
   function automatic logic [CHAN_WIDTH-1:0] k4_of(input side_type sd);
      return sd.t - sd.sa;
   endfunction

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff  <= MODE_NORMAL;
         src_opacity_ff <= CHAN_MAX;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BLEND_MODE:  blend_mode_ff  <= mode_type'(csr_data[2:0]);
            CSR_SRC_OPACITY: src_opacity_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign k4 = div255(kp3_ff);
   assign t4 = {1'b0, k4} + {1'b0, sa3_ff};

   always_comb begin
      side4_in.mode    = blend_mode_ff;
      side4_in.sa_zero = (sa3_ff == '0);
      side4_in.k_zero  = (k4 == '0);
      side4_in.da      = da3_ff;
      side4_in.sa      = sa3_ff;
      side4_in.t       = t4[CHAN_WIDTH-1:0];
      side4_in.d       = dc3_ff;
      side4_in.s       = sc3_ff;
   end

   // numerator and divisor per channel
   always_comb begin
      logic [CHAN_WIDTH-1:0] d, s, nd, den;
      logic [PROD_WIDTH-1:0] num;
      for (int c = 0; c < COLORS; c++) begin
         d  = side5_ff.d[c];
         s  = side5_ff.s[c];
         nd = CHAN_MAX - d;
         unique case (side5_ff.mode)
            MODE_NORMAL: begin
               num = pa5_ff[c] + pb5_ff[c];
               den = side5_ff.t;
            end
            MODE_ADD, MODE_SUB: begin
               if (side5_ff.da > side5_ff.sa) begin
                  num = pb5_ff[c];
                  den = side5_ff.da;
               end else begin
                  num = pf5_ff[c];
                  den = side5_ff.sa;
               end
            end
            MODE_MULTIPLY, MODE_SCREEN: begin
               num = (side5_ff.mode == MODE_SCREEN) ? pd5_ff[c] : pc5_ff[c];
               den = CHAN_MAX;
            end
            MODE_DODGE: begin
               num = {d, {CHAN_WIDTH{1'b0}}} - {{CHAN_WIDTH{1'b0}}, d};
               den = CHAN_MAX - s;
            end
            MODE_BURN: begin
               num = {nd, {CHAN_WIDTH{1'b0}}} - {{CHAN_WIDTH{1'b0}}, nd};
               den = s;
            end
            MODE_OVERLAY: begin
               num = (d < CHAN_HALF) ? {pc5_ff[c][PROD_WIDTH-2:0], 1'b0} : pc5_ff[c];
               den = CHAN_MAX;
            end
            default: begin
               num = '0;
               den = CHAN_MAX;
            end
         endcase
         num6_in[c] = num;
         den6_in[c] = (den == '0) ? {{(CHAN_WIDTH-1){1'b0}}, 1'b1} : den;
      end
   end

   // one restoring step per divider stage
   always_comb begin
      logic [CHAN_WIDTH:0]   trial;
      logic [PROD_WIDTH-1:0] nq;
      logic [CHAN_WIDTH-1:0] rem;
      for (int i = 0; i < DIV_STAGES; i++) begin
         for (int c = 0; c < COLORS; c++) begin
            if (i == 0) begin
               nq  = num6_ff[c];
               rem = '0;
               den_src[i][c] = den6_ff[c];
            end else begin
               nq  = nq_ff[i-1][c];
               rem = rem_ff[i-1][c];
               den_src[i][c] = den_ff[i-1][c];
            end
            trial = {rem, nq[PROD_WIDTH-1]};
            if (trial >= {1'b0, den_src[i][c]}) begin
               trial = trial - {1'b0, den_src[i][c]};
               nq_in[i][c] = {nq[PROD_WIDTH-2:0], 1'b1};
            end else begin
               nq_in[i][c] = {nq[PROD_WIDTH-2:0], 1'b0};
            end
            rem_in[i][c] = trial[CHAN_WIDTH-1:0];
         end
      end
   end

   // final combine and clamp
   always_comb begin
      side_type              sd;
      logic signed [SW-1:0]  q, d, s, r, full;
      sd   = sdiv_ff[DIV_STAGES-1];
      full = SW'(CHAN_MAX);
      for (int c = 0; c < COLORS; c++) begin
         q = SW'(nq_ff[DIV_STAGES-1][c]);
         d = SW'(sd.d[c]);
         s = SW'(sd.s[c]);
         unique case (sd.mode)
            MODE_NORMAL:   r = sd.k_zero ? s : q;
            MODE_ADD: begin
               if (sd.da == sd.sa)     r = d + s;
               else if (sd.da > sd.sa) r = d + q;
               else                    r = q + s;
            end
            MODE_SUB: begin
               if (sd.da == sd.sa)     r = d - s;
               else if (sd.da > sd.sa) r = d - q;
               else                    r = q - s;
            end
            MODE_MULTIPLY: r = q;
            MODE_DODGE:    r = (sd.s[c] == CHAN_MAX) ? full : q;
            MODE_BURN:     r = (sd.s[c] == '0) ? '0 : full - q;
            MODE_SCREEN:   r = full - q;
            MODE_OVERLAY: begin
               if (sd.d[c] < CHAN_HALF) r = q;
               else r = ((d + s - q) <<< 1) - full;
            end
            default:       r = '0;
         endcase
         if (sd.sa_zero)   out_color_in[c] = sd.d[c];
         else if (r < 0)   out_color_in[c] = '0;
         else if (r > full) out_color_in[c] = CHAN_MAX;
         else              out_color_in[c] = r[CHAN_WIDTH-1:0];
      end
      if (sd.sa_zero)
         out_alpha_in = sd.da;
      else if (sd.mode == MODE_NORMAL)
         out_alpha_in = sd.k_zero ? sd.sa : sd.t;
      else if (sd.mode == MODE_ADD || sd.mode == MODE_SUB)
         out_alpha_in = (sd.da >= sd.sa) ? sd.da : sd.sa;
      else
         out_alpha_in = CHAN_MAX;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         vdiv_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= start && !busy;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         vdiv_ff      <= {vdiv_ff[DIV_STAGES-2:0], v6_ff};
         out_valid_ff <= vdiv_ff[DIV_STAGES-1];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      dc1_ff <= {req_dst_blue, req_dst_green, req_dst_red};
      sc1_ff <= {req_src_blue, req_src_green, req_src_red};
      da1_ff <= req_dst_alpha;
      p1_ff  <= PROD_WIDTH'(req_src_alpha) * PROD_WIDTH'(src_opacity_ff);

      dc2_ff <= dc1_ff;
      sc2_ff <= sc1_ff;
      da2_ff <= da1_ff;
      sa2_ff <= div255(p1_ff);

      dc3_ff <= dc2_ff;
      sc3_ff <= sc2_ff;
      da3_ff <= da2_ff;
      sa3_ff <= sa2_ff;
      kp3_ff <= PROD_WIDTH'(da2_ff) * PROD_WIDTH'(CHAN_MAX - sa2_ff);

      side4_ff <= side4_in;

      side5_ff <= side4_ff;
      for (int c = 0; c < COLORS; c++) begin
         pa5_ff[c] <= PROD_WIDTH'(side4_ff.d[c]) * PROD_WIDTH'(k4_of(side4_ff));
         pb5_ff[c] <= PROD_WIDTH'(side4_ff.s[c]) * PROD_WIDTH'(side4_ff.sa);
         pc5_ff[c] <= PROD_WIDTH'(side4_ff.d[c]) * PROD_WIDTH'(side4_ff.s[c]);
         pd5_ff[c] <= PROD_WIDTH'(CHAN_MAX - side4_ff.d[c])
                      * PROD_WIDTH'(CHAN_MAX - side4_ff.s[c]);
         pf5_ff[c] <= PROD_WIDTH'(side4_ff.d[c]) * PROD_WIDTH'(side4_ff.da);
      end

      side6_ff <= side5_ff;
      num6_ff  <= num6_in;
      den6_ff  <= den6_in;

      sdiv_ff[0] <= side6_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         sdiv_ff[i] <= sdiv_ff[i-1];
      end
      for (int i = 0; i < DIV_STAGES; i++) begin
         nq_ff[i]   <= nq_in[i];
         rem_ff[i]  <= rem_in[i];
         den_ff[i]  <= den_src[i];
      end

      out_color_ff <= out_color_in;
      out_alpha_ff <= out_alpha_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_red   = out_color_ff[0];
   assign rsp_out_green = out_color_ff[1];
   assign rsp_out_blue  = out_color_ff[2];
   assign rsp_out_alpha = out_alpha_ff;

endmodule
